// ===== rtl/core/alr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// alr_pkg: shared types and constants for the antialiased line rasteriser
// Item structs for the command and pixel channels, line modes, sequencer
// states and the small control structs between the submodules.
// ----------------------------------------------------------------------------
package alr_pkg;

	// fixed field widths
	localparam int COORD_BITS    = 12;
	localparam int COV_BITS      = 8;
	localparam int COLOR_BITS    = 32;
	localparam int FRAC_BITS_DEF = 16;

	localparam logic [COV_BITS-1:0] COV_FULL = '1;

	// command op codes
	localparam logic OP_START   = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef enum logic [2:0] {
		MODE_VERT = 3'd0,
		MODE_HORZ = 3'd1,
		MODE_DIAG = 3'd2,
		MODE_WU_Y = 3'd3,
		MODE_WU_X = 3'd4
	} line_mode_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_DIV  = 1'b1
	} seq_state_t;

	typedef struct packed {
		logic                  op;
		coord_t                start_x;
		coord_t                start_y;
		coord_t                end_x;
		coord_t                end_y;
		logic [COLOR_BITS-1:0] color;
	} cmd_item_t;

	typedef struct packed {
		coord_t                pixel_x;
		coord_t                pixel_y;
		logic [COV_BITS-1:0]   coverage;
		logic                  blend;
		logic [COLOR_BITS-1:0] pixel_color;
		logic                  segment_done;
	} pix_item_t;

	// write request into the output buffer
	typedef struct packed {
		logic wr;
		logic two;
	} obuf_wr_t;

	// divider status
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/alr_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// alr_div: iterative restoring divider for the Wu error increment
// Computes (numer << FRAC_BITS) / denom for numer < denom, one quotient bit
// per cycle through one shared compare-and-subtract unit.
// ----------------------------------------------------------------------------
module alr_div #(
	parameter int FRAC_BITS = alr_pkg::FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  alr_pkg::coord_t          numer,
	input  alr_pkg::coord_t          denom,
	output alr_pkg::div_stat_t       status,
	output logic [FRAC_BITS-1:0]     quo
);
	import alr_pkg::*;

	localparam int CNT_W = $clog2(FRAC_BITS + 1);

	coord_t               rem_q;
	coord_t               den_q;
	logic [FRAC_BITS-1:0] quo_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [COORD_BITS:0]  shifted;
	logic [COORD_BITS:0]  diff;
	logic                 ge;

	// shared compare and subtract
	always_comb begin
		shifted = {rem_q, 1'b0};
		diff    = shifted - {1'b0, den_q};
		ge      = shifted >= {1'b0, den_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(FRAC_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath: remainder stays below the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= numer;
			den_q <= denom;
		end else if (busy_q) begin
			rem_q <= ge ? diff[COORD_BITS-1:0] : shifted[COORD_BITS-1:0];
			quo_q <= {quo_q[FRAC_BITS-2:0], ge};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quo         = quo_q;

	// checks
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider restarted while busy");
	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0) else $error("divider busy with zero count");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < den_q) else $error("remainder not below divisor");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q)) else $error("stray divider done");

endmodule
`default_nettype wire

// ===== rtl/core/alr_obuf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// alr_obuf: pixel output register with one pending slot
// Takes one or two pixel writes in a cycle and hands them out one beat at a
// time, holding the payload while the receiver stalls.
// ----------------------------------------------------------------------------
module alr_obuf (
	input  logic                clk,
	input  logic                arst_n,
	input  alr_pkg::obuf_wr_t   wr,
	input  alr_pkg::pix_item_t  r0,
	input  alr_pkg::pix_item_t  r1,
	output logic                ready,
	output logic                pix_valid,
	input  logic                pix_stall,
	output alr_pkg::pix_item_t  pix
);
	import alr_pkg::*;

	pix_item_t out_q;
	pix_item_t pend_q;
	logic      out_valid_q;
	logic      pend_valid_q;
	logic      slot_free;

	assign slot_free = !out_valid_q || !pix_stall;
	assign ready     = slot_free && !pend_valid_q;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (wr.wr) begin
			out_valid_q  <= 1'b1;
			pend_valid_q <= wr.two;
		end else if (slot_free) begin
			out_valid_q  <= pend_valid_q;
			pend_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (wr.wr) begin
			out_q  <= r0;
			pend_q <= r1;
		end else if (slot_free && pend_valid_q) begin
			out_q <= pend_q;
		end
	end

	assign pix_valid = out_valid_q;
	assign pix       = out_q;

	// checks
	a_pend_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> out_valid_q) else $error("pending beat without head beat");
	a_wr_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		wr.wr |-> ready) else $error("write into full output buffer");
	a_pend_moves_up: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q && slot_free |=> out_valid_q && !pend_valid_q)
		else $error("pending beat lost");

endmodule
`default_nettype wire

// ===== rtl/core/antialiased_line_rasterizer_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer_top: Wu antialiased line pixel-write generator
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel takes one item per beat. A start item (op = start) latches a
//   clipped segment and colour and yields the two endpoint pixels; each
//   advance item yields the next interior step: one full pixel, or two
//   blended pixels in Wu mode. The last pixel of a segment has segment_done.
//   An advance with no running segment yields nothing.
//   pix channel carries one pixel write per beat from an output register;
//   the first pixel of an item is offered the cycle after the item is taken.
//   Throughput: one-pixel steps run at one item per cycle while pix does not stall;
//   a two-pixel item holds off the next while its second pixel waits in the
//   pending slot, set by the single pixel port. A Wu start also runs the shared
//   compare-subtract divider for the error increment, one quotient bit a cycle,
//   and the next item waits until the divider is done. A stall on pix holds the
//   payload; cmd_stall rises as soon as the output register and its pending slot
//   cannot take a whole item. Reset (arst_n low) clears segment state and empties the output.
// ----------------------------------------------------------------------------
module antialiased_line_rasterizer_top #(
	parameter int FRAC_BITS = alr_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  alr_pkg::cmd_item_t cmd,
	output logic               pix_valid,
	input  logic               pix_stall,
	output alr_pkg::pix_item_t pix
);
	import alr_pkg::*;

	localparam int ACC_W = COORD_BITS + FRAC_BITS;

	// segment state
	seq_state_t             state_q, state_d;
	logic                   active_q;
	line_mode_t             mode_q;
	coord_t                 major_pos_q;
	coord_t                 minor_base_q;
	logic                   step_dir_q;
	logic [ACC_W-1:0]       error_accum_q;
	logic [FRAC_BITS-1:0]   error_step_q;
	coord_t                 steps_left_q;
	logic [COLOR_BITS-1:0]  color_q;

	logic                   obuf_ready;
	logic                   cmd_fire;
	logic                   is_start;
	obuf_wr_t               obuf_wr;
	pix_item_t              r0, r1;

	div_stat_t              div_st;
	logic [FRAC_BITS-1:0]   div_quo;
	logic                   div_start;

	// start decode
	logic                   swap;
	coord_t                 sx0, sy0, sx1, sy1;
	coord_t                 dx, dy;
	logic                   st_dir;
	line_mode_t             st_mode;
	coord_t                 st_major, st_minor, st_major_pos, st_minor_base;
	coord_t                 st_steps;
	logic                   st_active;
	logic                   st_wu;

	always_comb begin
		swap = cmd.start_y > cmd.end_y;
		sx0  = swap ? cmd.end_x   : cmd.start_x;
		sy0  = swap ? cmd.end_y   : cmd.start_y;
		sx1  = swap ? cmd.start_x : cmd.end_x;
		sy1  = swap ? cmd.start_y : cmd.end_y;
		dy     = sy1 - sy0;
		st_dir = sx1 < sx0;
		dx     = st_dir ? (sx0 - sx1) : (sx1 - sx0);
		st_minor = dx;
		if (dx == '0) begin
			st_mode       = MODE_VERT;
			st_major      = dy;
			st_major_pos  = sy0;
			st_minor_base = sx0;
		end else if (dy == '0) begin
			st_mode       = MODE_HORZ;
			st_major      = dx;
			st_major_pos  = st_dir ? sx1 : sx0;
			st_minor_base = sy0;
		end else if (dx == dy) begin
			st_mode       = MODE_DIAG;
			st_major      = dy;
			st_major_pos  = sy0;
			st_minor_base = sx0;
		end else if (dy > dx) begin
			st_mode       = MODE_WU_Y;
			st_major      = dy;
			st_major_pos  = sy0;
			st_minor_base = sx0;
		end else begin
			st_mode       = MODE_WU_X;
			st_major      = dx;
			st_minor      = dy;
			st_major_pos  = sx0;
			st_minor_base = sy0;
		end
		st_steps  = (st_major != '0) ? (st_major - 1'b1) : '0;
		st_active = st_steps != '0;
		st_wu     = (st_mode == MODE_WU_Y) || (st_mode == MODE_WU_X);
	end

	// advance step
	logic                   adv_live;
	coord_t                 sl_n;
	logic                   adv_done;
	logic [ACC_W-1:0]       acc_n;
	coord_t                 off;
	logic [COV_BITS-1:0]    t;
	coord_t                 mp_inc, mp_dec, mp_n, mb_n, p;
	logic                   adv_two;
	pix_item_t              a0, a1;

	always_comb begin
		adv_live = active_q && (steps_left_q != '0);
		sl_n     = steps_left_q - 1'b1;
		adv_done = sl_n == '0;
		acc_n    = error_accum_q + ACC_W'(error_step_q);
		off      = acc_n[ACC_W-1:FRAC_BITS];
		t        = acc_n[FRAC_BITS-1 -: COV_BITS];
		mp_inc   = major_pos_q + 1'b1;
		mp_dec   = major_pos_q - 1'b1;
		mp_n     = mp_inc;
		mb_n     = minor_base_q;
		p        = minor_base_q + off;
		adv_two  = 1'b0;
		a0 = '{pixel_x: minor_base_q, pixel_y: mp_inc, coverage: COV_FULL,
			blend: 1'b0, pixel_color: color_q, segment_done: adv_done};
		a1 = a0;
		case (mode_q)
			MODE_HORZ: begin
				a0.pixel_x = mp_inc;
				a0.pixel_y = minor_base_q;
			end
			MODE_DIAG: begin
				mb_n = step_dir_q ? (minor_base_q - 1'b1) : (minor_base_q + 1'b1);
				a0.pixel_x = mb_n;
			end
			MODE_WU_Y: begin
				adv_two = 1'b1;
				if (step_dir_q) begin
					p = minor_base_q - off;
				end
				a0 = '{pixel_x: p, pixel_y: mp_inc, coverage: COV_FULL - t,
					blend: 1'b1, pixel_color: color_q, segment_done: 1'b0};
				a1 = a0;
				a1.pixel_x      = step_dir_q ? (p - 1'b1) : (p + 1'b1);
				a1.coverage     = t;
				a1.segment_done = adv_done;
			end
			MODE_WU_X: begin
				adv_two = 1'b1;
				mp_n    = step_dir_q ? mp_dec : mp_inc;
				a0 = '{pixel_x: mp_n, pixel_y: p, coverage: COV_FULL - t,
					blend: 1'b1, pixel_color: color_q, segment_done: 1'b0};
				a1 = a0;
				a1.pixel_y      = p + 1'b1;
				a1.coverage     = t;
				a1.segment_done = adv_done;
			end
			default: begin
			end
		endcase
	end

	// results into the output buffer
	assign cmd_fire  = cmd_valid && !cmd_stall;
	assign is_start  = cmd.op == OP_START;
	assign div_start = cmd_fire && is_start && st_wu;

	always_comb begin
		obuf_wr.wr  = cmd_fire && (is_start || adv_live);
		obuf_wr.two = is_start || adv_two;
		if (is_start) begin
			r0 = '{pixel_x: sx0, pixel_y: sy0, coverage: COV_FULL, blend: 1'b0,
				pixel_color: cmd.color, segment_done: 1'b0};
			r1 = '{pixel_x: sx1, pixel_y: sy1, coverage: COV_FULL, blend: 1'b0,
				pixel_color: cmd.color, segment_done: !st_active};
		end else begin
			r0 = a0;
			r1 = a1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				cmd_stall = !obuf_ready;
				if (div_start) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_st.done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// segment registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= 1'b0;
			mode_q        <= MODE_VERT;
			major_pos_q   <= '0;
			minor_base_q  <= '0;
			step_dir_q    <= 1'b0;
			error_accum_q <= '0;
			error_step_q  <= '0;
			steps_left_q  <= '0;
			color_q       <= '0;
		end else if (cmd_fire && is_start) begin
			active_q      <= st_active;
			mode_q        <= st_mode;
			major_pos_q   <= st_major_pos;
			minor_base_q  <= st_minor_base;
			step_dir_q    <= st_dir;
			error_accum_q <= '0;
			error_step_q  <= '0;
			steps_left_q  <= st_steps;
			color_q       <= cmd.color;
		end else if (cmd_fire) begin
			if (adv_live) begin
				active_q     <= !adv_done;
				steps_left_q <= sl_n;
				major_pos_q  <= mp_n;
				minor_base_q <= mb_n;
				if (adv_two) begin
					error_accum_q <= acc_n;
				end
			end else begin
				active_q <= 1'b0;
			end
		end else if (state_q == ST_DIV && div_st.done) begin
			error_step_q <= div_quo;
		end
	end

	alr_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (st_minor),
		.denom  (st_major),
		.status (div_st),
		.quo    (div_quo)
	);

	alr_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (obuf_wr),
		.r0        (r0),
		.r1        (r1),
		.ready     (obuf_ready),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix)
	);

	// checks
	a_div_only_wu: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> (mode_q == MODE_WU_Y || mode_q == MODE_WU_X))
		else $error("divider run for a non-Wu segment");
	a_active_steps: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> steps_left_q != '0) else $error("active segment with no steps");
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> state_q == ST_DIV) else $error("divider finished outside run");
	a_div_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.busy |-> cmd_stall) else $error("command taken during division");

endmodule
`default_nettype wire
